// ===== sv/ssa_pkg.sv =====
// Shared types and constants of the slab slot allocator.
package ssa_pkg;

   // Function codes of a request beat
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Configuration register indexes
   localparam int   CSR_INDEX_W     = 1;
   localparam logic CSR_REGION_BASE = 1'b0;
   localparam logic CSR_OBJECT_SIZE = 1'b1;

   localparam int ADDR_W = 32;
   localparam int SIZE_W = 8;

   localparam logic [ADDR_W-1:0] REGION_BASE_RESET = 32'd0;
   localparam logic [SIZE_W-1:0] OBJECT_SIZE_RESET = 8'd64;

   typedef enum logic [1:0] {
      STATUS_ALLOC   = 2'd0,
      STATUS_FAIL    = 2'd1,
      STATUS_FREED   = 2'd2,
      STATUS_IGNORED = 2'd3
   } status_type;

   typedef enum logic {
      OP_ALLOC,
      OP_FREE
   } op_type;

   typedef struct packed {
      logic              func;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] object_address;
   } rsp_type;

   // Classified command handed from the front end to the engine
   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] address;
   } cmd_type;

   typedef struct packed {
      logic [ADDR_W-1:0] region_base;
      logic [SIZE_W-1:0] object_size;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_READ,
      ST_A_CHECK,
      ST_A_NEW,
      ST_A_MUL,
      ST_A_SUM,
      ST_F_SCAN,
      ST_F_DIV,
      ST_F_READ,
      ST_F_CHECK,
      ST_DONE
   } eng_state_type;

endpackage

// ===== sv/ssa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ssa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ssa_front.sv =====
// Request front end: accept a beat, classify it and hold it for the queue.
module ssa_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ssa_pkg::req_type  req,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output ssa_pkg::cmd_type  cmd
);

   logic             hold_valid_ff;
   logic             hold_valid_in;
   ssa_pkg::cmd_type hold_ff;
   ssa_pkg::cmd_type hold_in;
   logic             take;

   assign req_ready = !hold_valid_ff || cmd_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      hold_in = hold_ff;
      if (take) begin
         if (req.func == ssa_pkg::FUNC_FREE) begin
            hold_in.op      = ssa_pkg::OP_FREE;
            hold_in.address = req.free_address;
         end else begin
            // address is meaningless on allocate: drop it
            hold_in.op      = ssa_pkg::OP_ALLOC;
            hold_in.address = '0;
         end
      end
   end

   always_comb begin
      if (take) begin
         hold_valid_in = 1'b1;
      end else if (cmd_ready) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

   assign cmd_valid = hold_valid_ff;
   assign cmd       = hold_ff;

endmodule

// ===== sv/ssa_fifo.sv =====
// Short command queue between the front end and the engine.
module ssa_fifo #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ssa_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ssa_pkg::cmd_type pop_data
);

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   ssa_pkg::cmd_type mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNTW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNTW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNTW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/ssa_engine.sv =====
// Allocation engine: slab scan, slot pick, address divide and map update.
module ssa_engine #(
   parameter int SLOTS_PER_SLAB = 32,
   parameter int MAX_SLABS      = 16,
   parameter int SLAB_BYTES     = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  ssa_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  ssa_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssa_pkg::rsp_type rsp
);

   localparam int KW    = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
   localparam int CW    = $clog2(MAX_SLABS + 1);
   localparam int SLOTW = (SLOTS_PER_SLAB > 1) ? $clog2(SLOTS_PER_SLAB) : 1;
   localparam int OFFW  = $clog2(SLOTS_PER_SLAB * 256);
   localparam int CNTW  = $clog2(OFFW + 1);
   localparam int SW    = ssa_pkg::SIZE_W;
   localparam int AW    = ssa_pkg::ADDR_W;
   localparam int PW    = SLOTW + SW;

   localparam logic [AW-1:0]             SLAB_STEP  = AW'(SLAB_BYTES);
   localparam logic [SLOTS_PER_SLAB-1:0] FIRST_SLOT = SLOTS_PER_SLAB'(1);

   ssa_pkg::eng_state_type state_ff, state_in;

   logic [KW-1:0]      k_ff, k_in;
   logic [AW-1:0]      start_ff, start_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [CW-1:0]      created_ff, created_in;
   logic [AW-1:0]      next_off_ff, next_off_in;
   logic [SLOTW-1:0]   slot_ff, slot_in;
   logic [PW-1:0]      prod_ff, prod_in;
   logic [OFFW-1:0]    q_ff, q_in;
   logic [SW-1:0]      rem_ff, rem_in;
   logic [CNTW-1:0]    cnt_ff, cnt_in;
   logic [SW-1:0]      size_eff_ff;
   logic [OFFW-1:0]    span_ff;
   ssa_pkg::status_type res_status_ff, res_status_in;
   logic [AW-1:0]      res_addr_ff, res_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ssa_pkg::rsp_type   rsp_ff, rsp_in;

   logic                      wr_en;
   logic [KW-1:0]             wr_addr;
   logic [SLOTS_PER_SLAB-1:0] wr_data;
   logic [SLOTS_PER_SLAB-1:0] map_rd;

   logic [SLOTW-1:0]          first_free;
   logic                      found;
   logic [AW-1:0]             off_full;
   logic                      hit;
   logic                      k_zero;
   logic [SW:0]               trial;
   logic [SW:0]               trial_diff;
   logic                      ge;
   logic                      out_free;
   logic                      accept;
   logic [CW-1:0]             created_dec;
   logic [SLOTS_PER_SLAB-1:0] take_mask;
   logic [SLOTS_PER_SLAB-1:0] free_mask;

   ssa_ram #(
      .WIDTH (SLOTS_PER_SLAB),
      .DEPTH (MAX_SLABS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (k_ff),
      .rd_data (map_rd)
   );

   // Lowest free slot of the slab word just read
   always_comb begin
      first_free = '0;
      for (int i = SLOTS_PER_SLAB - 1; i >= 0; i--) begin
         if (map_rd[i]) begin
            first_free = SLOTW'(i);
         end
      end
   end

   assign found       = |map_rd;
   assign take_mask   = FIRST_SLOT << first_free;
   assign free_mask   = FIRST_SLOT << slot_ff;
   assign off_full    = addr_ff - start_ff;
   assign hit         = (off_full < AW'(span_ff));
   assign k_zero      = (k_ff == '0);
   assign trial       = {rem_ff, q_ff[OFFW-1]};
   assign trial_diff  = trial - {1'b0, size_eff_ff};
   assign ge          = (trial >= {1'b0, size_eff_ff});
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign cmd_ready   = (state_ff == ssa_pkg::ST_IDLE);
   assign accept      = cmd_valid && cmd_ready;
   assign created_dec = CW'(created_ff - 1'b1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssa_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == ssa_pkg::OP_ALLOC) begin
                  state_in = (created_ff == '0) ? ssa_pkg::ST_A_NEW : ssa_pkg::ST_A_READ;
               end else begin
                  state_in = (created_ff == '0) ? ssa_pkg::ST_DONE : ssa_pkg::ST_F_SCAN;
               end
            end
         end
         ssa_pkg::ST_A_READ:  state_in = ssa_pkg::ST_A_CHECK;
         ssa_pkg::ST_A_CHECK: begin
            if (found) begin
               state_in = ssa_pkg::ST_A_MUL;
            end else if (k_zero) begin
               state_in = ssa_pkg::ST_A_NEW;
            end else begin
               state_in = ssa_pkg::ST_A_READ;
            end
         end
         ssa_pkg::ST_A_NEW: begin
            state_in = (created_ff < CW'(MAX_SLABS)) ? ssa_pkg::ST_A_MUL : ssa_pkg::ST_DONE;
         end
         ssa_pkg::ST_A_MUL:   state_in = ssa_pkg::ST_A_SUM;
         ssa_pkg::ST_A_SUM:   state_in = ssa_pkg::ST_DONE;
         ssa_pkg::ST_F_SCAN: begin
            if (hit) begin
               state_in = ssa_pkg::ST_F_DIV;
            end else if (k_zero) begin
               state_in = ssa_pkg::ST_DONE;
            end
         end
         ssa_pkg::ST_F_DIV: begin
            if (cnt_ff == CNTW'(OFFW - 1)) begin
               state_in = ssa_pkg::ST_F_READ;
            end
         end
         ssa_pkg::ST_F_READ:  state_in = ssa_pkg::ST_F_CHECK;
         ssa_pkg::ST_F_CHECK: state_in = ssa_pkg::ST_DONE;
         ssa_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = ssa_pkg::ST_IDLE;
            end
         end
         default: state_in = ssa_pkg::ST_IDLE;
      endcase
   end

   // Datapath and map port
   always_comb begin
      k_in          = k_ff;
      start_in      = start_ff;
      addr_in       = addr_ff;
      created_in    = created_ff;
      next_off_in   = next_off_ff;
      slot_in       = slot_ff;
      prod_in       = prod_ff;
      q_in          = q_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      wr_en         = 1'b0;
      wr_addr       = k_ff;
      wr_data       = map_rd;
      unique case (state_ff)
         ssa_pkg::ST_IDLE: begin
            if (accept) begin
               // start at the newest slab
               k_in          = created_dec[KW-1:0];
               start_in      = cfg.region_base + next_off_ff - SLAB_STEP;
               addr_in       = cmd.address;
               res_addr_in   = '0;
               res_status_in = (cmd.op == ssa_pkg::OP_ALLOC) ? ssa_pkg::STATUS_ALLOC
                                                             : ssa_pkg::STATUS_IGNORED;
            end
         end
         ssa_pkg::ST_A_READ: begin
         end
         ssa_pkg::ST_A_CHECK: begin
            if (found) begin
               wr_en   = 1'b1;
               wr_data = map_rd & ~take_mask;
               slot_in = first_free;
            end else if (!k_zero) begin
               k_in     = KW'(k_ff - 1'b1);
               start_in = start_ff - SLAB_STEP;
            end
         end
         ssa_pkg::ST_A_NEW: begin
            if (created_ff < CW'(MAX_SLABS)) begin
               // create the next slab with slot 0 already taken
               wr_en       = 1'b1;
               wr_addr     = created_ff[KW-1:0];
               wr_data     = ~FIRST_SLOT;
               slot_in     = '0;
               start_in    = cfg.region_base + next_off_ff;
               created_in  = CW'(created_ff + 1'b1);
               next_off_in = next_off_ff + SLAB_STEP;
            end else begin
               res_status_in = ssa_pkg::STATUS_FAIL;
            end
         end
         ssa_pkg::ST_A_MUL: begin
            prod_in = PW'(slot_ff) * PW'(size_eff_ff);
         end
         ssa_pkg::ST_A_SUM: begin
            res_addr_in   = start_ff + AW'(prod_ff);
            res_status_in = ssa_pkg::STATUS_ALLOC;
         end
         ssa_pkg::ST_F_SCAN: begin
            if (hit) begin
               q_in   = off_full[OFFW-1:0];
               rem_in = '0;
               cnt_in = '0;
            end else if (!k_zero) begin
               k_in     = KW'(k_ff - 1'b1);
               start_in = start_ff - SLAB_STEP;
            end
         end
         ssa_pkg::ST_F_DIV: begin
            // one restoring quotient bit per cycle
            q_in   = {q_ff[OFFW-2:0], ge};
            rem_in = ge ? trial_diff[SW-1:0] : trial[SW-1:0];
            cnt_in = CNTW'(cnt_ff + 1'b1);
         end
         ssa_pkg::ST_F_READ: begin
            slot_in = q_ff[SLOTW-1:0];
         end
         ssa_pkg::ST_F_CHECK: begin
            if ((map_rd & free_mask) == '0) begin
               wr_en         = 1'b1;
               wr_data       = map_rd | free_mask;
               res_status_in = ssa_pkg::STATUS_FREED;
            end
         end
         ssa_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ssa_pkg::ST_DONE && out_free) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = res_status_ff;
         rsp_in.object_address = res_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssa_pkg::ST_IDLE;
         created_ff   <= '0;
         next_off_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         created_ff   <= created_in;
         next_off_ff  <= next_off_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff          <= k_in;
      start_ff      <= start_in;
      addr_ff       <= addr_in;
      slot_ff       <= slot_in;
      prod_ff       <= prod_in;
      q_ff          <= q_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_ff        <= rsp_in;
      size_eff_ff   <= (cfg.object_size == '0) ? SW'(1) : cfg.object_size;
      span_ff       <= OFFW'(SLOTS_PER_SLAB) * OFFW'(size_eff_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== sv/slab_slot_allocator_unit.sv =====
// Slab slot allocator top level: CSRs, front end, command queue and engine.
// Allocate scans the slabs newest first, skipping full ones; when all are full a slab opens, or
//   the request is refused. Free scans for its slab, then divides the offset by the slot size,
//   OFFW = log2(SLOTS_PER_SLAB*256) divider bits (13 by default).
// The engine takes one command at a time; the front end and a 2-entry queue keep taking beats
//   meanwhile.
// Reset (synchronous, active high): no slabs created, region_base 0, object_size 64.
module slab_slot_allocator_unit #(
   parameter int SLOTS_PER_SLAB = 32,
   parameter int MAX_SLABS      = 16,
   parameter int SLAB_BYTES     = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ssa_pkg::req_type                    req,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ssa_pkg::rsp_type                    rsp,
   input  logic                                csr_write_enable,
   input  logic [ssa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ssa_pkg::ADDR_W-1:0]          csr_write_data
);

   // Configuration registers; the user must write them only while idle, the block does not enforce it
   logic [ssa_pkg::ADDR_W-1:0] region_base_ff, region_base_in;
   logic [ssa_pkg::SIZE_W-1:0] object_size_ff, object_size_in;
   ssa_pkg::cfg_type           cfg;

   // Front end to queue
   logic             front_valid;
   logic             front_ready;
   ssa_pkg::cmd_type front_cmd;

   // Queue to engine
   logic             queue_valid;
   logic             queue_ready;
   ssa_pkg::cmd_type queue_cmd;

   always_comb begin
      region_base_in = region_base_ff;
      object_size_in = object_size_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            ssa_pkg::CSR_REGION_BASE: region_base_in = csr_write_data;
            ssa_pkg::CSR_OBJECT_SIZE: object_size_in = csr_write_data[ssa_pkg::SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= ssa_pkg::REGION_BASE_RESET;
         object_size_ff <= ssa_pkg::OBJECT_SIZE_RESET;
      end else begin
         region_base_ff <= region_base_in;
         object_size_ff <= object_size_in;
      end
   end

   assign cfg.region_base = region_base_ff;
   assign cfg.object_size = object_size_ff;

   // Accept and classify request beats
   ssa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   // Decouple the front end from the engine
   ssa_fifo #(
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_cmd)
   );

   // Scan, divide and update the slab maps; hold the response in an output register
   ssa_engine #(
      .SLOTS_PER_SLAB (SLOTS_PER_SLAB),
      .MAX_SLABS      (MAX_SLABS),
      .SLAB_BYTES     (SLAB_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd       (queue_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // Only a successful allocate carries an address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != ssa_pkg::STATUS_ALLOC) |-> rsp.object_address == '0)
      else $error("non-allocate response carries a nonzero address");

   // Back pressure on requests only comes from a full queue behind a held beat
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> front_valid && !front_ready)
      else $error("request stalled without a blocked front end");

   // Reset leaves no response pending
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench of the slab slot allocator: directed table, then randomized traffic.
`timescale 1ns / 100ps

module testbench;

   localparam int SLOTS       = 32;
   localparam int SLABS       = 16;
   localparam int SLAB_BYTES  = 4096;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 60;

   // One row of the directed table: a request beat or a register write.
   // When typed is set, the expected response is the one written in the row.
   typedef struct packed {
      logic                       csr_row;
      logic                       typed;
      logic                       code;   // function code, or register index on a csr row
      logic [ssa_pkg::ADDR_W-1:0] value;  // free address, or register write data
      ssa_pkg::status_type        want_status;
      logic [ssa_pkg::ADDR_W-1:0] want_address;
   } plan_row_type;

   logic                            clock            = 1'b0;
   logic                            reset            = 1'b1;
   logic                            req_valid        = 1'b0;
   logic                            req_ready;
   ssa_pkg::req_type                req              = '0;
   logic                            rsp_valid;
   logic                            rsp_ready        = 1'b0;
   ssa_pkg::rsp_type                rsp;
   logic                            csr_write_enable = 1'b0;
   logic [ssa_pkg::CSR_INDEX_W-1:0] csr_index        = '0;
   logic [ssa_pkg::ADDR_W-1:0]      csr_write_data   = '0;

   // Shadow of the allocator state and its registers
   logic [SLOTS-1:0]           free_map [SLABS];
   int unsigned                slots_left [SLABS];
   int                         slab_total;
   logic [ssa_pkg::ADDR_W-1:0] cfg_base;
   logic [ssa_pkg::SIZE_W-1:0] cfg_size;

   ssa_pkg::rsp_type pending_outcomes [$];
   plan_row_type     directed_rows [$];

   int send_idle_pct;
   int rcv_idle_pct;
   int hold_request;
   int hold_left;
   int mismatches;
   int cycles;
   int refusals;
   int beats_sent;
   int csr_writes;
   int status_tally [4];

   slab_slot_allocator_unit #(
      .SLOTS_PER_SLAB (SLOTS),
      .MAX_SLABS      (SLABS),
      .SLAB_BYTES     (SLAB_BYTES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req              (req),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, pending_outcomes.size());
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   // A size of zero behaves as one byte per slot
   function automatic logic [ssa_pkg::ADDR_W-1:0] slot_bytes();
      return (cfg_size == '0) ? 32'd1 : {24'd0, cfg_size};
   endfunction

   // Start address of slab k; the sum wraps at 2^32
   function automatic logic [ssa_pkg::ADDR_W-1:0] slab_start(input int k);
      logic [ssa_pkg::ADDR_W-1:0] index;
      index = k;
      return cfg_base + index * SLAB_BYTES;
   endfunction

   // Apply one request beat to the shadow state and return the response it earns
   function automatic ssa_pkg::rsp_type allocator_outcome(input ssa_pkg::req_type beat);
      ssa_pkg::rsp_type           outcome;
      logic [ssa_pkg::ADDR_W-1:0] offset;
      logic [ssa_pkg::ADDR_W-1:0] slot;
      int                         k;
      int                         hit;
      int                         i;
      outcome.status         = ssa_pkg::STATUS_IGNORED;
      outcome.object_address = '0;
      offset                 = '0;
      hit                    = -1;
      k                      = slab_total - 1;
      if (beat.func == ssa_pkg::FUNC_ALLOC) begin
         // newest slab with a free slot wins
         while (k >= 0 && hit < 0) begin
            if (slots_left[k] != 0)
               hit = k;
            k--;
         end
         // all full: open the next slab if one is left
         if (hit < 0 && slab_total < SLABS) begin
            hit             = slab_total;
            free_map[hit]   = '1;
            slots_left[hit] = SLOTS;
            slab_total++;
         end
         if (hit < 0) begin
            outcome.status = ssa_pkg::STATUS_FAIL;
         end else begin
            i = 0;
            while (!free_map[hit][i])
               i++;
            free_map[hit][i] = 1'b0;
            slots_left[hit]--;
            slot                   = i;
            outcome.status         = ssa_pkg::STATUS_ALLOC;
            outcome.object_address = slab_start(hit) + slot * slot_bytes();
         end
      end else begin
         // newest slab whose slot range holds the wrapped offset takes the free
         while (k >= 0 && hit < 0) begin
            offset = beat.free_address - slab_start(k);
            if (offset < SLOTS * slot_bytes())
               hit = k;
            else
               k--;
         end
         if (hit >= 0) begin
            slot = offset / slot_bytes();
            if (!free_map[hit][slot]) begin
               free_map[hit][slot] = 1'b1;
               slots_left[hit]++;
               outcome.status = ssa_pkg::STATUS_FREED;
            end
         end
      end
      return outcome;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 100)
         $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   task automatic check_outcome(input ssa_pkg::rsp_type got);
      ssa_pkg::rsp_type want;
      if (pending_outcomes.size() == 0) begin
         report_mismatch($sformatf("unexpected response beat, status %0d address %h",
                                   got.status, got.object_address));
      end else begin
         want = pending_outcomes.pop_front();
         if (got.status != want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.object_address != want.object_address)
            report_mismatch($sformatf("object_address %h, expected %h",
                                      got.object_address, want.object_address));
      end
   endtask

   // Receive side: check every response beat, then pick ready for the next cycle.
   // A hold request from the stimulus turns into a long stall counted here.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            check_outcome(rsp);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Offer one beat, hold it until accepted, then record what it must produce.
   // Valid only drops when an idle cycle is drawn, so it never toggles within a step.
   task automatic send_beat(input ssa_pkg::req_type beat, input logic typed,
                            input ssa_pkg::rsp_type typed_rsp);
      ssa_pkg::rsp_type outcome;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= beat;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      outcome = allocator_outcome(beat);
      if (typed)
         outcome = typed_rsp;
      if (outcome.status == ssa_pkg::STATUS_FAIL)
         refusals++;
      status_tally[outcome.status]++;
      beats_sent++;
      pending_outcomes.push_back(outcome);
   endtask

   // Pause the sender until every response has come back
   task automatic await_results();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // Write one register; the caller has drained the block first
   task automatic write_csr(input logic [ssa_pkg::CSR_INDEX_W-1:0] index,
                            input logic [ssa_pkg::ADDR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (index == ssa_pkg::CSR_REGION_BASE)
         cfg_base = data;
      else
         cfg_size = data[ssa_pkg::SIZE_W-1:0];
      csr_writes++;
   endtask

   task automatic reconfigure(input logic [ssa_pkg::ADDR_W-1:0] base,
                              input logic [ssa_pkg::ADDR_W-1:0] size);
      await_results();
      write_csr(ssa_pkg::CSR_REGION_BASE, base);
      write_csr(ssa_pkg::CSR_OBJECT_SIZE, size);
   endtask

   // Draw one random beat. Frees mostly target live slots (at the slot start or
   // inside it); the rest are double frees and addresses anywhere.
   task automatic pick_beat(input int alloc_pct, output ssa_pkg::req_type beat);
      int                         live;
      int                         pick;
      int                         hit_slab;
      int                         hit_slot;
      int                         roll;
      logic [ssa_pkg::ADDR_W-1:0] slot;
      beat.free_address = $urandom;
      live              = 0;
      hit_slab          = 0;
      hit_slot          = 0;
      for (int k = 0; k < slab_total; k++)
         live += SLOTS - slots_left[k];
      roll = $urandom_range(99);
      if ($urandom_range(99) < alloc_pct) begin
         beat.func = ssa_pkg::FUNC_ALLOC;
      end else begin
         beat.func = ssa_pkg::FUNC_FREE;
         if (roll < 65 && live > 0) begin
            pick = $urandom_range(live - 1);
            for (int k = 0; k < slab_total; k++)
               for (int i = 0; i < SLOTS; i++)
                  if (!free_map[k][i]) begin
                     if (pick == 0) begin
                        hit_slab = k;
                        hit_slot = i;
                     end
                     pick--;
                  end
            slot              = hit_slot;
            beat.free_address = slab_start(hit_slab) + slot * slot_bytes();
            if ($urandom_range(1))
               beat.free_address += $urandom_range(slot_bytes() - 1);
         end else if (roll < 80 && slab_total > 0) begin
            // any slot of a created slab: a double free when it is already free
            slot              = $urandom_range(SLOTS - 1);
            beat.free_address = slab_start($urandom_range(slab_total - 1)) + slot * slot_bytes();
         end else if (roll < 90) begin
            // near the region, past the created slabs too
            beat.free_address = cfg_base + $urandom_range(SLABS * SLAB_BYTES + 2 * SLAB_BYTES);
         end
      end
   endtask

   task automatic send_random(input int count, input int alloc_pct);
      ssa_pkg::req_type beat;
      for (int n = 0; n < count; n++) begin
         pick_beat(alloc_pct, beat);
         send_beat(beat, 1'b0, '0);
      end
   endtask

   task automatic row_beat(input logic func, input logic [ssa_pkg::ADDR_W-1:0] address);
      plan_row_type row;
      row         = '0;
      row.code    = func;
      row.value   = address;
      directed_rows.push_back(row);
   endtask

   task automatic row_typed(input logic func, input logic [ssa_pkg::ADDR_W-1:0] address,
                            input ssa_pkg::status_type status,
                            input logic [ssa_pkg::ADDR_W-1:0] object_address);
      plan_row_type row;
      row              = '0;
      row.typed        = 1'b1;
      row.code         = func;
      row.value        = address;
      row.want_status  = status;
      row.want_address = object_address;
      directed_rows.push_back(row);
   endtask

   task automatic row_csr(input logic [ssa_pkg::CSR_INDEX_W-1:0] index,
                          input logic [ssa_pkg::ADDR_W-1:0] data);
      plan_row_type row;
      row         = '0;
      row.csr_row = 1'b1;
      row.code    = index;
      row.value   = data;
      directed_rows.push_back(row);
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin
      ssa_pkg::req_type beat;
      ssa_pkg::rsp_type typed_rsp;
      for (int k = 0; k < SLABS; k++) begin
         free_map[k]   = '0;
         slots_left[k] = 0;
      end
      slab_total    = 0;
      cfg_base      = ssa_pkg::REGION_BASE_RESET;
      cfg_size      = ssa_pkg::OBJECT_SIZE_RESET;
      hold_request  = 0;
      hold_left     = 0;
      send_idle_pct = 31;
      rcv_idle_pct  = 69;

      // Reset values: base 0, 64-byte slots
      row_typed(ssa_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, ssa_pkg::STATUS_ALLOC, 32'h0000_0000);
      row_typed(ssa_pkg::FUNC_ALLOC, 32'h0000_0000, ssa_pkg::STATUS_ALLOC, 32'h0000_0040);
      row_typed(ssa_pkg::FUNC_FREE,  32'h0000_0000, ssa_pkg::STATUS_FREED, 32'h0);
      // slot already free
      row_typed(ssa_pkg::FUNC_FREE,  32'h0000_0000, ssa_pkg::STATUS_IGNORED, 32'h0);
      // address inside slot 1 rounds down to it
      row_typed(ssa_pkg::FUNC_FREE,  32'h0000_0041, ssa_pkg::STATUS_FREED, 32'h0);
      // outside every slab, and one past the end of slab zero
      row_typed(ssa_pkg::FUNC_FREE,  32'hFFFF_FFFF, ssa_pkg::STATUS_IGNORED, 32'h0);
      row_typed(ssa_pkg::FUNC_FREE,  32'h0000_0800, ssa_pkg::STATUS_IGNORED, 32'h0);
      row_typed(ssa_pkg::FUNC_ALLOC, 32'h0000_0000, ssa_pkg::STATUS_ALLOC, 32'h0000_0000);
      row_typed(ssa_pkg::FUNC_FREE,  32'h0000_07FF, ssa_pkg::STATUS_IGNORED, 32'h0);
      // Zero size acts as one byte per slot
      row_csr(ssa_pkg::CSR_REGION_BASE, 32'hFFFF_F000);
      row_csr(ssa_pkg::CSR_OBJECT_SIZE, 32'h0000_0000);
      row_typed(ssa_pkg::FUNC_ALLOC, 32'h0000_0000, ssa_pkg::STATUS_ALLOC, 32'hFFFF_F001);
      row_typed(ssa_pkg::FUNC_FREE,  32'hFFFF_F000, ssa_pkg::STATUS_FREED, 32'h0);
      // Oversized slots with a base at the top: slot addresses wrap through zero;
      // the upper data bits of the size write are dropped
      row_csr(ssa_pkg::CSR_OBJECT_SIZE, 32'hABCD_EFFF);
      row_csr(ssa_pkg::CSR_REGION_BASE, 32'hFFFF_FFFF);
      row_beat(ssa_pkg::FUNC_ALLOC, 32'h5555_5555);
      row_beat(ssa_pkg::FUNC_ALLOC, 32'hAAAA_AAAA);
      row_beat(ssa_pkg::FUNC_FREE,  32'h0000_0200);
      row_beat(ssa_pkg::FUNC_FREE,  32'h0000_0000);
      // Largest regular size: the slots fill the slab exactly
      row_csr(ssa_pkg::CSR_OBJECT_SIZE, 32'h0000_0080);
      row_csr(ssa_pkg::CSR_REGION_BASE, 32'h0000_0000);
      row_beat(ssa_pkg::FUNC_ALLOC, 32'h0000_0000);
      row_beat(ssa_pkg::FUNC_ALLOC, 32'h0000_0000);
      row_beat(ssa_pkg::FUNC_FREE,  32'h0000_0FFF);
      row_beat(ssa_pkg::FUNC_FREE,  32'h0000_017F);

      // hold reset, then release it for good
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (directed_rows[n]) begin
         if (directed_rows[n].csr_row) begin
            await_results();
            write_csr(directed_rows[n].code, directed_rows[n].value);
         end else begin
            beat.func                = directed_rows[n].code;
            beat.free_address        = directed_rows[n].value;
            typed_rsp.status         = directed_rows[n].want_status;
            typed_rsp.object_address = directed_rows[n].want_address;
            send_beat(beat, directed_rows[n].typed, typed_rsp);
         end
      end

      // Phase one: random base and size, sender idles little, receiver a lot
      reconfigure($urandom, ($urandom & 32'hFFFF_FF00) | $urandom_range(1, 128));
      send_random(30, 80);
      // stall the receiver for a long stretch and keep offering beats back to back
      send_idle_pct = 0;
      hold_request  = 300;
      send_random(12, 80);
      send_idle_pct = 31;
      send_random(30, 80);

      // Phase two: oversized slots so that neighbouring slabs overlap, idling reversed
      send_idle_pct = 69;
      rcv_idle_pct  = 31;
      reconfigure(32'h0000_0000, 32'h0000_00FF);
      send_random(60, 65);

      // Phase three: no idling; the region straddles the wrap point.
      // Allocate until the last slab is taken and several allocations are refused.
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      reconfigure(32'hFFFF_8000, 32'hFFFF_FF01);
      for (int n = 0; n < 700 && refusals < 4; n++)
         send_random(1, 100);
      // free and reuse slots with every slab created
      send_random(16, 50);
      reconfigure($urandom, $urandom_range(1, 128));
      send_random(10, 50);

      // Drain, then watch for stray responses
      await_results();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d request beats: %0d allocated, %0d refused, %0d freed, %0d ignored",
               beats_sent, status_tally[ssa_pkg::STATUS_ALLOC],
               status_tally[ssa_pkg::STATUS_FAIL], status_tally[ssa_pkg::STATUS_FREED],
               status_tally[ssa_pkg::STATUS_IGNORED]);
      $display("%0d register writes, %0d of %0d slabs created, %0d mismatches",
               csr_writes, slab_total, SLABS, mismatches);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
